// ===== design/fbl_pkg.sv =====
// ----------------------------------------------------------------------------
// Five-bar leg torque mapping package
// Shared widths, fixed-point constants, the arctangent table and the item
// type that travels from the trigonometry front end to the torque back end.
// ----------------------------------------------------------------------------
package fbl_pkg;

	localparam int ANGLE_FRAC_BITS_DEF = 13;
	localparam int CORDIC_STEPS_DEF    = 16;
	localparam int CORDIC_MAX_STEPS    = 24;

	localparam int ANGLE_W  = 16;
	localparam int LEN_W    = 16;
	localparam int FORCE_W  = 24;
	localparam int TORQUE_W = 24;
	localparam int TRIG_W   = 18;
	localparam int CFG_W    = 32;
	localparam int APB_AW   = 3;

	localparam int IN_W   = 5 * ANGLE_W + LEN_W + 2 * FORCE_W;
	localparam int OUT_W  = 2 * TORQUE_W;
	localparam int USER_W = 2;
	localparam int USER_SING = 0;
	localparam int USER_SAT  = 1;

	// Range reduction works on the magnitude of the Q30 angle.
	localparam int RED_STEPS = 6;
	localparam int RED_W     = 40;
	// CORDIC datapath width, Q30 with headroom.
	localparam int CW        = 34;
	localparam int TRIG_SHIFT = 14;

	localparam logic [RED_W-1:0] TWO_PI_MAG = 40'd6746518852;
	localparam logic [RED_W-1:0] PI_MAG     = 40'd3373259426;
	localparam logic signed [CW-1:0] PI_Z      = 34'sd3373259426;
	localparam logic signed [CW-1:0] HALF_PI_Z = 34'sd1686629713;
	localparam logic signed [CW-1:0] INV_GAIN  = 34'sd652032874;
	localparam logic signed [CW-1:0] TRIG_HALF = 34'sd8192;

	localparam logic [30:0] ATAN_Q30 [CORDIC_MAX_STEPS] = '{
		31'd843314856, 31'd497837829, 31'd263043836, 31'd133525158,
		31'd67021686,  31'd33543515,  31'd16775850,  31'd8388437,
		31'd4194282,   31'd2097149,   31'd1048575,   31'd524287,
		31'd262143,    31'd131071,    31'd65535,     31'd32767,
		31'd16383,     31'd8191,      31'd4095,      31'd2047,
		31'd1023,      31'd511,       31'd255,       31'd127
	};

	// Torque back end
	localparam int QUOT_BITS  = 24;
	localparam int DEN_SHIFT  = 30;
	localparam int RND_SHIFT  = 29;
	localparam int TQ_SHIFT   = 14;
	localparam int JOINT_LAT  = 6 + QUOT_BITS + 1;
	localparam logic [TORQUE_W-1:0] LIM_POS = 24'h7FFFFF;
	localparam logic [TORQUE_W-1:0] LIM_NEG = 24'h800000;

	localparam int FIFO_DEPTH = 4;

	localparam logic [LEN_W-1:0] LINK_RESET = 16'd2458;
	localparam logic REG_FRONT_LINK = 1'b0;
	localparam logic REG_REAR_LINK  = 1'b1;

	typedef struct packed {
		logic signed [TRIG_W-1:0]  sin_d;
		logic signed [TRIG_W-1:0]  sin_a;
		logic signed [TRIG_W-1:0]  cos_a;
		logic signed [TRIG_W-1:0]  sin_b;
		logic signed [TRIG_W-1:0]  sin_c;
		logic signed [TRIG_W-1:0]  cos_c;
		logic signed [TRIG_W-1:0]  sin_e;
		logic [LEN_W-1:0]          leg_length;
		logic signed [FORCE_W-1:0] leg_force;
		logic signed [FORCE_W-1:0] hip_torque;
		logic                      sing;
	} fbl_item_t;

	function automatic int fbl_lane_lat(int steps);
		return steps + RED_STEPS + 4;
	endfunction

endpackage

// ===== design/five_bar_leg_vmc_torque_core.sv =====
// ----------------------------------------------------------------------------
// Five-bar leg torque mapping core
// Maps a virtual leg force and hip torque to the two joint motor torques.
// ----------------------------------------------------------------------------
// Input items arrive on the s_ channel: five joint angles, the virtual leg
// length, the leg force and the hip torque. Each accepted item gives exactly
// one result on the m_ channel: front and rear joint torques in tdata, the
// singular and saturated flags in tuser. Reset loads the default leg geometry.
// The user must set the link lengths over APB only while no item is in flight;
// the core itself does not enforce this.
// A front pipeline of five sine/cosine lanes (one CORDIC step per stage)
// feeds a four-entry queue; the back pipeline forms the products and resolves
// one quotient bit per stage. The core takes one item per cycle while results
// are taken as they appear.
//
// When m_tready is low on a valid result, the back pipeline holds it stable
// and the queue absorbs the front pipeline; s_tready drops once the queue is
// full while an item waits to enter. Reset empties the pipelines and the queue.
// ----------------------------------------------------------------------------
module five_bar_leg_vmc_torque_core #(
	parameter int ANGLE_FRAC_BITS = fbl_pkg::ANGLE_FRAC_BITS_DEF,
	parameter int CORDIC_STEPS    = fbl_pkg::CORDIC_STEPS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// leg_angle, front_motor_angle, front_knee_angle, rear_knee_angle,
	// rear_motor_angle, leg_length, leg_force, hip_torque
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [fbl_pkg::IN_W-1:0]    s_tdata,
	// front_torque, rear_torque
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [fbl_pkg::OUT_W-1:0]   m_tdata,
	// singular, saturated
	output logic [fbl_pkg::USER_W-1:0]  m_tuser,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [fbl_pkg::APB_AW-1:0]  paddr,
	input  logic [fbl_pkg::CFG_W-1:0]   pwdata,
	output logic [fbl_pkg::CFG_W-1:0]   prdata,
	output logic                        pready
);
	import fbl_pkg::*;

	logic [LEN_W-1:0] front_link_q;
	logic [LEN_W-1:0] rear_link_q;
	logic             wr_en;
	logic             push;
	logic             pop;
	logic             full;
	logic             empty;
	fbl_item_t        push_item;
	fbl_item_t        pop_item;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_link_q <= LINK_RESET;
			rear_link_q  <= LINK_RESET;
		end else if (wr_en) begin
			if (paddr[2] == REG_FRONT_LINK) begin
				front_link_q <= pwdata[LEN_W-1:0];
			end else begin
				rear_link_q <= pwdata[LEN_W-1:0];
			end
		end
	end

	assign prdata = (paddr[2] == REG_REAR_LINK) ? CFG_W'(rear_link_q) : CFG_W'(front_link_q);

	fbl_front #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_front (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.full(full), .push(push), .item(push_item)
	);

	fbl_fifo u_fifo (
		.clk(clk), .arst_n(arst_n),
		.push(push), .item_in(push_item),
		.pop(pop), .item_out(pop_item),
		.full(full), .empty(empty)
	);

	fbl_back u_back (
		.clk(clk), .arst_n(arst_n),
		.front_link(front_link_q), .rear_link(rear_link_q),
		.empty(empty), .item(pop_item), .pop(pop),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

endmodule

// ===== design/fbl_sincos.sv =====
// ----------------------------------------------------------------------------
// Sine and cosine lane
// Pipelined range reduction of an angle difference followed by one
// rotation-mode CORDIC step per stage. Results have 16 fraction bits.
// ----------------------------------------------------------------------------
module fbl_sincos #(
	parameter int ANGLE_FRAC_BITS = fbl_pkg::ANGLE_FRAC_BITS_DEF,
	parameter int CORDIC_STEPS    = fbl_pkg::CORDIC_STEPS_DEF
) (
	input  logic                               clk,
	input  logic                               en,
	input  logic signed [fbl_pkg::ANGLE_W-1:0] angle_a,
	input  logic signed [fbl_pkg::ANGLE_W-1:0] angle_b,
	output logic signed [fbl_pkg::TRIG_W-1:0]  sin_val,
	output logic signed [fbl_pkg::TRIG_W-1:0]  cos_val
);
	import fbl_pkg::*;

	localparam int SHIFT = 30 - ANGLE_FRAC_BITS;

	logic signed [ANGLE_W:0] diff;
	logic signed [RED_W:0]   z_ext;
	logic [RED_W-1:0]        mag_c;
	logic [RED_W-1:0]        mag_s [RED_STEPS+1];
	logic                    neg_s [RED_STEPS+1];
	logic signed [CW-1:0]    t_c;
	logic signed [CW-1:0]    v_fa;
	logic signed [CW-1:0]    x_s [CORDIC_STEPS+1];
	logic signed [CW-1:0]    y_s [CORDIC_STEPS+1];
	logic signed [CW-1:0]    z_s [CORDIC_STEPS+1];
	logic                    flip_s [CORDIC_STEPS+1];
	logic signed [CW-1:0]    x_fin;
	logic signed [CW-1:0]    y_fin;
	logic signed [CW-1:0]    x_rnd;
	logic signed [CW-1:0]    y_rnd;

	assign diff  = {angle_a[ANGLE_W-1], angle_a} - {angle_b[ANGLE_W-1], angle_b};
	assign z_ext = (RED_W+1)'(diff) <<< SHIFT;
	assign mag_c = RED_W'(z_ext[RED_W] ? -z_ext : z_ext);

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s[0] <= mag_c;
			neg_s[0] <= z_ext[RED_W];
		end
	end

	// Magnitude modulo two pi, one binary multiple of two pi per stage.
	for (genvar k = 0; k < RED_STEPS; k++) begin : g_red
		localparam logic [RED_W-1:0] MOD_K = TWO_PI_MAG << (RED_STEPS - 1 - k);
		always_ff @(posedge clk) begin
			if (en) begin
				mag_s[k+1] <= (mag_s[k] >= MOD_K) ? mag_s[k] - MOD_K : mag_s[k];
				neg_s[k+1] <= neg_s[k];
			end
		end
	end

	assign t_c = (mag_s[RED_STEPS] > PI_MAG) ?
		CW'(mag_s[RED_STEPS]) - CW'(TWO_PI_MAG) : CW'(mag_s[RED_STEPS]);

	always_ff @(posedge clk) begin
		if (en) begin
			v_fa <= neg_s[RED_STEPS] ? -t_c : t_c;
		end
	end

	// Fold into the right half plane; the result is negated at the end.
	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= INV_GAIN;
			y_s[0] <= '0;
			if (v_fa > HALF_PI_Z) begin
				z_s[0]    <= v_fa - PI_Z;
				flip_s[0] <= 1'b1;
			end else if (v_fa < -HALF_PI_Z) begin
				z_s[0]    <= v_fa + PI_Z;
				flip_s[0] <= 1'b1;
			end else begin
				z_s[0]    <= v_fa;
				flip_s[0] <= 1'b0;
			end
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		always_ff @(posedge clk) begin
			if (en) begin
				flip_s[i+1] <= flip_s[i];
				if (!z_s[i][CW-1]) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - CW'(ATAN_Q30[i]);
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + CW'(ATAN_Q30[i]);
				end
			end
		end
	end

	assign x_fin = flip_s[CORDIC_STEPS] ? -x_s[CORDIC_STEPS] : x_s[CORDIC_STEPS];
	assign y_fin = flip_s[CORDIC_STEPS] ? -y_s[CORDIC_STEPS] : y_s[CORDIC_STEPS];
	assign x_rnd = x_fin + TRIG_HALF;
	assign y_rnd = y_fin + TRIG_HALF;

	always_ff @(posedge clk) begin
		if (en) begin
			sin_val <= TRIG_W'(y_rnd >>> TRIG_SHIFT);
			cos_val <= TRIG_W'(x_rnd >>> TRIG_SHIFT);
		end
	end

endmodule

// ===== design/fbl_front.sv =====
// ----------------------------------------------------------------------------
// Trigonometry front end
// Accepts input items, runs five sine/cosine lanes in parallel and marks
// items whose divisor is zero before they enter the queue.
// ----------------------------------------------------------------------------
module fbl_front #(
	parameter int ANGLE_FRAC_BITS = fbl_pkg::ANGLE_FRAC_BITS_DEF,
	parameter int CORDIC_STEPS    = fbl_pkg::CORDIC_STEPS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [fbl_pkg::IN_W-1:0]     s_tdata,
	input  logic                         full,
	output logic                         push,
	output fbl_pkg::fbl_item_t           item
);
	import fbl_pkg::*;

	localparam int LAT = fbl_lane_lat(CORDIC_STEPS);

	logic                      en;
	logic [LAT-1:0]            v_q;
	logic signed [ANGLE_W-1:0] leg_angle;
	logic signed [ANGLE_W-1:0] front_motor_angle;
	logic signed [ANGLE_W-1:0] front_knee_angle;
	logic signed [ANGLE_W-1:0] rear_knee_angle;
	logic signed [ANGLE_W-1:0] rear_motor_angle;
	logic [LEN_W-1:0]          leg_length;
	logic signed [FORCE_W-1:0] leg_force;
	logic signed [FORCE_W-1:0] hip_torque;
	logic [LEN_W-1:0]          len_s [LAT];
	logic signed [FORCE_W-1:0] force_s [LAT];
	logic signed [FORCE_W-1:0] torque_s [LAT];
	logic signed [TRIG_W-1:0]  sin_d, sin_a, cos_a, sin_b, sin_c, cos_c, sin_e;

	assign leg_angle         = s_tdata[15:0];
	assign front_motor_angle = s_tdata[31:16];
	assign front_knee_angle  = s_tdata[47:32];
	assign rear_knee_angle   = s_tdata[63:48];
	assign rear_motor_angle  = s_tdata[79:64];
	assign leg_length        = s_tdata[95:80];
	assign leg_force         = s_tdata[119:96];
	assign hip_torque        = s_tdata[143:120];

	// The whole pipeline holds only when its last item cannot enter the queue.
	assign en       = !(v_q[LAT-1] && full);
	assign s_tready = en;
	assign push     = v_q[LAT-1] && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[LAT-2:0], s_tvalid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			len_s[0]    <= leg_length;
			force_s[0]  <= leg_force;
			torque_s[0] <= hip_torque;
			for (int k = 1; k < LAT; k++) begin
				len_s[k]    <= len_s[k-1];
				force_s[k]  <= force_s[k-1];
				torque_s[k] <= torque_s[k-1];
			end
		end
	end

	fbl_sincos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_lane_d (
		.clk(clk), .en(en), .angle_a(rear_knee_angle), .angle_b(front_knee_angle),
		.sin_val(sin_d), .cos_val()
	);
	fbl_sincos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_lane_a (
		.clk(clk), .en(en), .angle_a(leg_angle), .angle_b(rear_knee_angle),
		.sin_val(sin_a), .cos_val(cos_a)
	);
	fbl_sincos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_lane_b (
		.clk(clk), .en(en), .angle_a(front_motor_angle), .angle_b(front_knee_angle),
		.sin_val(sin_b), .cos_val()
	);
	fbl_sincos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_lane_c (
		.clk(clk), .en(en), .angle_a(leg_angle), .angle_b(front_knee_angle),
		.sin_val(sin_c), .cos_val(cos_c)
	);
	fbl_sincos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_lane_e (
		.clk(clk), .en(en), .angle_a(rear_knee_angle), .angle_b(rear_motor_angle),
		.sin_val(sin_e), .cos_val()
	);

	always_comb begin
		item.sin_d      = sin_d;
		item.sin_a      = sin_a;
		item.cos_a      = cos_a;
		item.sin_b      = sin_b;
		item.sin_c      = sin_c;
		item.cos_c      = cos_c;
		item.sin_e      = sin_e;
		item.leg_length = len_s[LAT-1];
		item.leg_force  = force_s[LAT-1];
		item.hip_torque = torque_s[LAT-1];
		item.sing       = (len_s[LAT-1] == '0) || (sin_d == '0);
	end

endmodule

// ===== design/fbl_fifo.sv =====
// ----------------------------------------------------------------------------
// Item queue
// Short register queue between the front end and the back end.
// ----------------------------------------------------------------------------
module fbl_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  fbl_pkg::fbl_item_t item_in,
	input  logic               pop,
	output fbl_pkg::fbl_item_t item_out,
	output logic               full,
	output logic               empty
);
	import fbl_pkg::*;

	localparam int AW = $clog2(FIFO_DEPTH);

	fbl_item_t    mem_q [FIFO_DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [AW:0]   cnt_q;

	assign full     = cnt_q == (AW+1)'(FIFO_DEPTH);
	assign empty    = cnt_q == '0;
	assign item_out = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("item pushed into a full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("item popped from an empty queue");
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("queue count lost a pushed item");

endmodule

// ===== design/fbl_joint.sv =====
// ----------------------------------------------------------------------------
// Joint torque datapath
// Forms the numerator and divisor of one joint torque, rounds with a
// restoring division of one quotient bit per stage, then saturates.
// ----------------------------------------------------------------------------
module fbl_joint (
	input  logic                                clk,
	input  logic                                en,
	input  logic [fbl_pkg::LEN_W-1:0]           link,
	input  logic signed [fbl_pkg::TRIG_W-1:0]   s_num,
	input  logic signed [fbl_pkg::TRIG_W-1:0]   s_v,
	input  logic signed [fbl_pkg::TRIG_W-1:0]   c_v,
	input  logic signed [fbl_pkg::TRIG_W-1:0]   s_d,
	input  logic [fbl_pkg::LEN_W-1:0]           len,
	input  logic signed [fbl_pkg::FORCE_W-1:0]  force_in,
	input  logic signed [fbl_pkg::FORCE_W-1:0]  torque_in,
	output logic signed [fbl_pkg::TORQUE_W-1:0] torque_out,
	output logic                                sat
);
	import fbl_pkg::*;

	localparam int SVL_W = TRIG_W + LEN_W + 1;
	localparam int CT_W  = TRIG_W + FORCE_W;
	localparam int LM_W  = LEN_W + TRIG_W;
	localparam int IW    = SVL_W + FORCE_W + 1;
	localparam int IM_W  = IW - 1;
	localparam int LO_W  = 30;
	localparam int HI_W  = IM_W - LO_W;
	localparam int NW    = IM_W + LM_W + 1;

	logic [TRIG_W-1:0]         num_mag;
	logic [TRIG_W-1:0]         den_mag;
	logic signed [SVL_W-1:0]   svl_s1;
	logic signed [CT_W-1:0]    ct_s1;
	logic signed [FORCE_W-1:0] f_s1;
	logic [LM_W-1:0]           lm_s1, lm_s2, lm_s3;
	logic [LM_W-1:0]           dm_s1, dm_s2, dm_s3, dm_s4, dm_s5;
	logic                      nsg_s1, nsg_s2;
	logic signed [IW-1:0]      prod_c;
	logic signed [IW-1:0]      ctx_c;
	logic signed [IW-1:0]      inner_s2;
	logic [IM_W-1:0]           im_s3;
	logic                      neg_s3, neg_s4, neg_s5;
	logic [LO_W+LM_W-1:0]      pl_s4;
	logic [HI_W+LM_W-1:0]      ph_s4;
	logic [NW-1:0]             n_s5;
	logic [NW-1:0]             rem_d [QUOT_BITS+1];
	logic [QUOT_BITS-1:0]      q_d [QUOT_BITS+1];
	logic [LM_W-1:0]           dm_d [QUOT_BITS+1];
	logic                      neg_d [QUOT_BITS+1];
	logic                      presat_d [QUOT_BITS+1];
	logic [TORQUE_W-1:0]       lim;
	logic                      over;
	logic [TORQUE_W-1:0]       q_fin;

	assign num_mag = s_num[TRIG_W-1] ? TRIG_W'(-s_num) : TRIG_W'(s_num);
	assign den_mag = s_d[TRIG_W-1] ? TRIG_W'(-s_d) : TRIG_W'(s_d);

	always_ff @(posedge clk) begin
		if (en) begin
			svl_s1 <= s_v * $signed({1'b0, len});
			ct_s1  <= c_v * torque_in;
			f_s1   <= force_in;
			lm_s1  <= link * num_mag;
			dm_s1  <= len * den_mag;
			nsg_s1 <= s_num[TRIG_W-1] ^ s_d[TRIG_W-1];
		end
	end

	assign prod_c = svl_s1 * f_s1;
	assign ctx_c  = IW'(ct_s1) <<< TQ_SHIFT;

	always_ff @(posedge clk) begin
		if (en) begin
			inner_s2 <= prod_c + ctx_c;
			lm_s2    <= lm_s1;
			dm_s2    <= dm_s1;
			nsg_s2   <= nsg_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			im_s3  <= IM_W'(inner_s2[IW-1] ? -inner_s2 : inner_s2);
			neg_s3 <= inner_s2[IW-1] ^ nsg_s2;
			lm_s3  <= lm_s2;
			dm_s3  <= dm_s2;
		end
	end

	// The wide product is split into two partial products.
	always_ff @(posedge clk) begin
		if (en) begin
			pl_s4  <= im_s3[LO_W-1:0] * lm_s3;
			ph_s4  <= im_s3[IM_W-1:LO_W] * lm_s3;
			dm_s4  <= dm_s3;
			neg_s4 <= neg_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_s5   <= (NW'(ph_s4) << LO_W) + NW'(pl_s4) + (NW'(dm_s4) << RND_SHIFT);
			dm_s5  <= dm_s4;
			neg_s5 <= neg_s4;
		end
	end

	// A quotient of 2^24 or more always saturates, so 24 bits are resolved.
	always_ff @(posedge clk) begin
		if (en) begin
			rem_d[0]    <= n_s5;
			q_d[0]      <= '0;
			dm_d[0]     <= dm_s5;
			neg_d[0]    <= neg_s5;
			presat_d[0] <= n_s5 >= (NW'(dm_s5) << (DEN_SHIFT + QUOT_BITS));
		end
	end

	for (genvar k = 0; k < QUOT_BITS; k++) begin : g_div
		localparam int J = QUOT_BITS - 1 - k;
		logic [NW-1:0] dsh;
		assign dsh = NW'(dm_d[k]) << (DEN_SHIFT + J);
		always_ff @(posedge clk) begin
			if (en) begin
				dm_d[k+1]     <= dm_d[k];
				neg_d[k+1]    <= neg_d[k];
				presat_d[k+1] <= presat_d[k];
				if (rem_d[k] >= dsh) begin
					rem_d[k+1] <= rem_d[k] - dsh;
					q_d[k+1]   <= q_d[k] | (QUOT_BITS'(1) << J);
				end else begin
					rem_d[k+1] <= rem_d[k];
					q_d[k+1]   <= q_d[k];
				end
			end
		end
	end

	assign lim   = neg_d[QUOT_BITS] ? LIM_NEG : LIM_POS;
	assign over  = presat_d[QUOT_BITS] || (q_d[QUOT_BITS] > lim);
	assign q_fin = over ? lim : q_d[QUOT_BITS];

	always_ff @(posedge clk) begin
		if (en) begin
			torque_out <= neg_d[QUOT_BITS] ? -q_fin : q_fin;
			sat        <= over;
		end
	end

endmodule

// ===== design/fbl_back.sv =====
// ----------------------------------------------------------------------------
// Torque back end
// Pops classified items from the queue, computes both joint torques and
// holds the result in the output stage until it is taken.
// ----------------------------------------------------------------------------
module fbl_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [fbl_pkg::LEN_W-1:0]     front_link,
	input  logic [fbl_pkg::LEN_W-1:0]     rear_link,
	input  logic                          empty,
	input  fbl_pkg::fbl_item_t            item,
	output logic                          pop,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [fbl_pkg::OUT_W-1:0]     m_tdata,
	output logic [fbl_pkg::USER_W-1:0]    m_tuser
);
	import fbl_pkg::*;

	logic                       en;
	logic [JOINT_LAT-1:0]       v_q;
	logic                       sing_s [JOINT_LAT];
	logic signed [TORQUE_W-1:0] front_t;
	logic signed [TORQUE_W-1:0] rear_t;
	logic                       front_sat;
	logic                       rear_sat;
	logic                       sing;

	assign en  = !(v_q[JOINT_LAT-1] && !m_tready);
	assign pop = en && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[JOINT_LAT-2:0], !empty};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sing_s[0] <= item.sing;
			for (int k = 1; k < JOINT_LAT; k++) begin
				sing_s[k] <= sing_s[k-1];
			end
		end
	end

	fbl_joint u_front (
		.clk(clk), .en(en), .link(front_link),
		.s_num(item.sin_b), .s_v(item.sin_a), .c_v(item.cos_a), .s_d(item.sin_d),
		.len(item.leg_length), .force_in(item.leg_force), .torque_in(item.hip_torque),
		.torque_out(front_t), .sat(front_sat)
	);

	fbl_joint u_rear (
		.clk(clk), .en(en), .link(rear_link),
		.s_num(item.sin_e), .s_v(item.sin_c), .c_v(item.cos_c), .s_d(item.sin_d),
		.len(item.leg_length), .force_in(item.leg_force), .torque_in(item.hip_torque),
		.torque_out(rear_t), .sat(rear_sat)
	);

	assign sing     = sing_s[JOINT_LAT-1];
	assign m_tvalid = v_q[JOINT_LAT-1];

	always_comb begin
		m_tdata            = sing ? '0 : {rear_t, front_t};
		m_tuser            = '0;
		m_tuser[USER_SING] = sing;
		m_tuser[USER_SAT]  = !sing && (front_sat || rear_sat);
	end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Five-bar leg torque core testbench
// Drives angle, length, force and torque items with bursty traffic, stalls
// the result side, rewrites both link lengths between phases, and compares each
// result with a bit-exact CORDIC and long-division predictor or a preset result.
// ----------------------------------------------------------------------------
module tb_top;
	import fbl_pkg::*;

	localparam logic [APB_AW-1:0] ADDR_FRONT_LINK = 3'd0;
	localparam logic [APB_AW-1:0] ADDR_REAR_LINK  = 3'd4;
	localparam longint PI_Q30      = 64'sd3373259426;
	localparam longint TWO_PI_Q30  = 64'sd6746518852;
	localparam longint HALF_PI_Q30 = 64'sd1686629713;
	localparam longint START_X     = 64'sd652032874;
	localparam int     ITEMS_PER_PHASE = 210;
	localparam int     NUM_PHASES      = 6;
	localparam int     IDLE_LIMIT      = 5000;

	typedef struct {
		logic signed [ANGLE_W-1:0] ang [5];
		logic [LEN_W-1:0]          len;
		logic signed [FORCE_W-1:0] force_v;
		logic signed [FORCE_W-1:0] torque_v;
	} leg_item_t;

	typedef struct {
		logic [TORQUE_W-1:0] front;
		logic [TORQUE_W-1:0] rear;
		logic                sing;
		logic                sat;
	} torque_res_t;

	typedef struct {
		leg_item_t   item;
		bit          typed;
		torque_res_t res;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;
	logic [USER_W-1:0] m_tuser;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [APB_AW-1:0] paddr = '0;
	logic [CFG_W-1:0] pwdata = '0;
	logic [CFG_W-1:0] prdata;
	logic pready;

	longint unsigned front_link = 2458;
	longint unsigned rear_link  = 2458;
	torque_res_t pending_torques[$];
	dir_row_t dir_tab[$];
	int errors = 0;
	int n_results = 0;
	int n_sing = 0;
	int n_sat = 0;
	int idle_cycles = 0;
	int ready_pct = 100;
	int max_gap = 0;

	five_bar_leg_vmc_torque_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Sine and cosine of an angle difference, 16 fraction bits.
	function automatic void leg_trig(input longint diff, output longint sn, output longint cs);
		longint z, x, y, k, t;
		bit flip;
		z = diff * (64'sd1 <<< (30 - ANGLE_FRAC_BITS_DEF));
		x = START_X;
		y = 0;
		flip = 0;
		k = z / TWO_PI_Q30;
		z = z - k * TWO_PI_Q30;
		if (z > PI_Q30) z = z - TWO_PI_Q30;
		if (z < -PI_Q30) z = z + TWO_PI_Q30;
		if (z > HALF_PI_Q30) begin
			z = z - PI_Q30;
			flip = 1;
		end else if (z < -HALF_PI_Q30) begin
			z = z + PI_Q30;
			flip = 1;
		end
		for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
			if (z >= 0) begin
				t = x - (y >>> i);
				y = y + (x >>> i);
				z = z - longint'(ATAN_Q30[i]);
			end else begin
				t = x + (y >>> i);
				y = y - (x >>> i);
				z = z + longint'(ATAN_Q30[i]);
			end
			x = t;
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		sn = (y + 8192) >>> 14;
		cs = (x + 8192) >>> 14;
	endfunction

	function automatic longint joint_torque(input longint unsigned link, input longint s_num,
			input longint s_v, input longint c_v, input longint f, input longint tp,
			input longint len, input longint s_d, inout bit sat);
		longint inner;
		bit neg;
		logic [127:0] im, lm, den, num, q, lim;
		inner = s_v * f * len + c_v * tp * 16384;
		neg = (inner < 0) != ((s_num < 0) != (s_d < 0));
		im = inner < 0 ? -inner : inner;
		lm = 128'(link) * 128'(s_num < 0 ? -s_num : s_num);
		den = (128'(len) * 128'(s_d < 0 ? -s_d : s_d)) << 30;
		num = im * lm + (den >> 1);
		q = num / den;
		lim = neg ? 128'd8388608 : 128'd8388607;
		if (q > lim) begin
			q = lim;
			sat = 1;
		end
		return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
	endfunction

	function automatic torque_res_t predict_torques(input leg_item_t it);
		torque_res_t r;
		longint p [5];
		longint sd, cd, sa, ca, sb, cb, sc, cc, se, ce, t1, t2;
		bit sat;
		for (int i = 0; i < 5; i++) p[i] = longint'(it.ang[i]);
		leg_trig(p[3] - p[2], sd, cd);
		leg_trig(p[0] - p[3], sa, ca);
		leg_trig(p[1] - p[2], sb, cb);
		leg_trig(p[0] - p[2], sc, cc);
		leg_trig(p[3] - p[4], se, ce);
		sat = 0;
		t1 = 0;
		t2 = 0;
		r.sing = (it.len == 0) || (sd == 0);
		if (!r.sing) begin
			t1 = joint_torque(front_link, sb, sa, ca, longint'(it.force_v),
				longint'(it.torque_v), longint'(it.len), sd, sat);
			t2 = joint_torque(rear_link, se, sc, cc, longint'(it.force_v),
				longint'(it.torque_v), longint'(it.len), sd, sat);
		end
		r.front = t1[TORQUE_W-1:0];
		r.rear = t2[TORQUE_W-1:0];
		r.sat = sat;
		return r;
	endfunction

	task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [CFG_W-1:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// The core keeps only the low 16 bits of a link length.
	task automatic set_links(input longint unsigned fl, input longint unsigned rl);
		apb_write(ADDR_FRONT_LINK, CFG_W'(fl));
		apb_write(ADDR_REAR_LINK, CFG_W'(rl));
		front_link = fl & 64'hFFFF;
		rear_link = rl & 64'hFFFF;
	endtask

	task automatic add_dir_row(input leg_item_t it, input bit typed, input torque_res_t res);
		dir_tab.insert(dir_tab.size(), '{it, typed, res});
	endtask

	// Burst state of the sender: items left in the burst before a gap.
	int burst_left = 0;

	task automatic send_leg_item(input leg_item_t it, input bit typed, input torque_res_t res);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = $urandom_range(0, max_gap);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= {it.torque_v, it.force_v, it.len,
			it.ang[4], it.ang[3], it.ang[2], it.ang[1], it.ang[0]};
		do @(posedge clk); while (!s_tready);
		pending_torques.insert(pending_torques.size(), typed ? res : predict_torques(it));
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (pending_torques.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic leg_item_t random_leg_item();
		leg_item_t it;
		for (int i = 0; i < 5; i++) begin
			// Mostly a draw of 0 to 60000 read as signed, sometimes any 16-bit angle.
			if ($urandom_range(3) == 0) it.ang[i] = 16'($urandom);
			else it.ang[i] = $signed(16'($urandom_range(0, 60000))) ;
		end
		case ($urandom_range(5))
			0: it.len = 16'($urandom_range(0, 16));
			1: it.len = 16'hFFFF - 16'($urandom_range(0, 16));
			default: it.len = 16'($urandom);
		endcase
		it.force_v = ($urandom_range(3) == 0) ? 24'($urandom) : 24'($signed(12'($urandom)));
		it.torque_v = ($urandom_range(3) == 0) ? 24'($urandom) : 24'($signed(12'($urandom)));
		return it;
	endfunction

	always @(posedge clk) m_tready <= ($urandom_range(0, 99) < ready_pct);

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			torque_res_t exp_r;
			if (pending_torques.size() == 0) begin
				$display("%0t: result with nothing expected: tdata=%h tuser=%b",
					$realtime, m_tdata, m_tuser);
				errors++;
			end else begin
				exp_r = pending_torques.pop_front();
				n_results++;
				if (exp_r.sing) n_sing++;
				if (exp_r.sat) n_sat++;
				if (m_tdata[TORQUE_W-1:0] !== exp_r.front) begin
					$display("%0t: front_torque expected %h got %h",
						$realtime, exp_r.front, m_tdata[TORQUE_W-1:0]);
					errors++;
				end
				if (m_tdata[OUT_W-1:TORQUE_W] !== exp_r.rear) begin
					$display("%0t: rear_torque expected %h got %h",
						$realtime, exp_r.rear, m_tdata[OUT_W-1:TORQUE_W]);
					errors++;
				end
				if (m_tuser[USER_SING] !== exp_r.sing) begin
					$display("%0t: singular expected %b got %b",
						$realtime, exp_r.sing, m_tuser[USER_SING]);
					errors++;
				end
				if (m_tuser[USER_SAT] !== exp_r.sat) begin
					$display("%0t: saturated expected %b got %b",
						$realtime, exp_r.sat, m_tuser[USER_SAT]);
					errors++;
				end
			end
		end
	end

	// Watchdog on cycles where neither side moves an item.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $realtime, IDLE_LIMIT);
			$display("[five_bar_leg_vmc_torque_core] ERROR");
			$finish;
		end
	end

	initial begin
		torque_res_t sing_res;
		torque_res_t none;
		leg_item_t it;
		longint unsigned fl_tab [NUM_PHASES];
		longint unsigned rl_tab [NUM_PHASES];
		int rdy_tab [NUM_PHASES];
		int gap_tab [NUM_PHASES];

		sing_res = '{front: '0, rear: '0, sing: 1'b1, sat: 1'b0};
		none = '{front: '0, rear: '0, sing: 1'b0, sat: 1'b0};
		// With the knees together the CORDIC residue leaves a divisor sine of one LSB.
		add_dir_row('{'{0, 0, 0, 0, 0}, 16384, 1000, 1000}, 0, none);
		add_dir_row('{'{12868, 20000, 4000, 9000, 2000}, 0, 8388607, -8388608}, 1, sing_res);
		add_dir_row('{'{12868, 25000, 1000, 1000, -3000}, 20000, 5000, 700}, 0, none);
		add_dir_row('{'{12868, 20000, 4000, 9000, 2000}, 16384, 2560, 256}, 0, none);
		add_dir_row('{'{12868, 23000, 3000, 22000, 2500}, 4000, -2560, -512}, 0, none);
		add_dir_row('{'{32767, 32767, -32768, 32767, -32768}, 65535, 8388607, 8388607}, 0, none);
		add_dir_row('{'{-32768, -32768, 32767, -32768, 32767}, 1, -8388608, -8388608}, 0, none);
		add_dir_row('{'{12868, 20000, 4000, 9000, 2000}, 1, 8388607, 8388607}, 0, none);
		add_dir_row('{'{12868, 20000, 4000, 9000, 2000}, 1, -8388608, -8388608}, 0, none);
		add_dir_row('{'{12868, 20000, 4000, 9000, 2000}, 65535, 8388607, -8388608}, 0, none);
		add_dir_row('{'{0, 5000, 4000, 4001, 3000}, 16384, 100000, 50000}, 0, none);
		add_dir_row('{'{-1, -1, -1, 0, -1}, 16384, -1, -1}, 0, none);
		// Knees pi apart: the divisor sine is a single LSB.
		add_dir_row('{'{1000, 2000, -12868, 12868, 0}, 16384, 4000, 4000}, 0, none);

		fl_tab = '{2458, 0, 65535, 65535, 1, 3000};
		rl_tab = '{2458, 65535, 0, 65535, 1, 2000};
		rdy_tab = '{100, 70, 40, 90, 20, 60};
		gap_tab = '{0, 3, 8, 1, 5, 2};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (dir_tab[i]) send_leg_item(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].res);
		drain_results();

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			ready_pct = rdy_tab[ph];
			max_gap = gap_tab[ph];
			if (ph == NUM_PHASES - 1) set_links($urandom, $urandom);
			else set_links(fl_tab[ph], rl_tab[ph]);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				it = random_leg_item();
				send_leg_item(it, 0, none);
			end
			drain_results();
		end

		ready_pct = 100;
		repeat (80) @(posedge clk);
		$display("Checked %0d torque results over %0d link settings and stall patterns.",
			n_results, NUM_PHASES + 1);
		$display("Results with singular set: %0d, with saturation: %0d.", n_sing, n_sat);
		if (errors == 0 && pending_torques.size() == 0) begin
			$display("[five_bar_leg_vmc_torque_core] OK");
		end else begin
			$display("[five_bar_leg_vmc_torque_core] ERROR");
		end
		$finish;
	end

endmodule
